### rtl/core/cit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cit_pkg
// Shared types and constants for the card information tuple parser.
// ----------------------------------------------------------------------------
package cit_pkg;

    // walk limits
    localparam int unsigned MAX_TUPLES        = 64;
    localparam int unsigned IMAGE_BYTES       = 6144;
    localparam int unsigned MAX_VERSION_CHARS = 79;

    // tuple codes
    localparam logic [7:0] CODE_NULL    = 8'h00;
    localparam logic [7:0] CODE_END     = 8'hFF;
    localparam logic [7:0] CODE_MANF    = 8'h20;
    localparam logic [7:0] CODE_CONFIG  = 8'h1A;
    localparam logic [7:0] CODE_VERSION = 8'h15;
    localparam logic [7:0] LINK_END     = 8'hFF;

    // character handling and defaults
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [1:0]  SIZE_MASK    = 2'b11;
    localparam logic [15:0] BASE_DEFAULT = 16'h0400;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // end reasons
    localparam logic [1:0] END_CODE   = 2'd0;
    localparam logic [1:0] END_LINK   = 2'd1;
    localparam logic [1:0] END_BOUND  = 2'd2;
    localparam logic [1:0] END_TUPLES = 2'd3;

    // one result item
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  char_value;
        logic [6:0]  char_position;
        logic [15:0] manufacturer_id;
        logic [15:0] card_id;
        logic [15:0] config_base;
        logic [6:0]  version_length;
        logic [1:0]  end_reason;
        logic        last;
    } t_result;

    // results produced by one input transfer, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage
`default_nettype wire

### rtl/core/cit_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cit_in_if / cit_out_if
// Valid/ready channels for attribute bytes in and parse results out.
// ----------------------------------------------------------------------------
interface cit_in_if;
    logic       valid;
    logic       ready;
    logic       start_of_image;
    logic [7:0] attr_byte;

    modport source (output valid, output start_of_image, output attr_byte, input ready);
    modport sink   (input valid, input start_of_image, input attr_byte, output ready);
endinterface

interface cit_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  char_value;
    logic [6:0]  char_position;
    logic [15:0] manufacturer_id;
    logic [15:0] card_id;
    logic [15:0] config_base;
    logic [6:0]  version_length;
    logic [1:0]  end_reason;
    logic        last;

    modport source (
        output valid, output result_kind, output char_value, output char_position,
        output manufacturer_id, output card_id, output config_base,
        output version_length, output end_reason, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input char_value, input char_position,
        input manufacturer_id, input card_id, input config_base,
        input version_length, input end_reason, input last, output ready
    );
endinterface
`default_nettype wire

### rtl/core/cit_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cit_walker
// Per-byte tuple walk: holds the parse state and forms up to two results
// for every accepted attribute byte.
// ----------------------------------------------------------------------------
module cit_walker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic          i_start_of_image,
    input  wire logic [7:0]    i_attr_byte,
    output cit_pkg::t_push     o_push
);
    import cit_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CODE,
        PH_LINK,
        PH_BODY,
        PH_DONE
    } t_phase;

    localparam logic [13:0] BOUND      = 14'(IMAGE_BYTES);
    localparam logic [7:0]  TUPLE_CAP  = 8'(MAX_TUPLES);
    localparam logic [6:0]  CHAR_CAP   = 7'(MAX_VERSION_CHARS);

    t_phase      r_phase,  n_phase;
    logic [12:0] r_start,  n_start;
    logic [7:0]  r_code,   n_code;
    logic [7:0]  r_link,   n_link;
    logic [7:0]  r_body,   n_body;
    logic [7:0]  r_seen,   n_seen;
    logic [1:0]  r_size,   n_size;
    logic [15:0] r_vendor, n_vendor;
    logic [15:0] r_card,   n_card;
    logic [15:0] r_base,   n_base;
    logic [6:0]  r_chars,  n_chars;
    logic [6:0]  r_trim,   n_trim;

    // working copies after a possible restart
    t_phase      c_phase;
    logic [12:0] c_start;
    logic [7:0]  c_link;
    logic [7:0]  c_code;
    logic [7:0]  c_body;
    logic [7:0]  c_seen;
    logic [1:0]  c_size;
    logic [15:0] c_vendor;
    logic [15:0] c_card;
    logic [15:0] c_base;
    logic [6:0]  c_chars;
    logic [6:0]  c_trim;

    logic        end_code;
    logic        complete;
    logic        do_adv;
    logic [8:0]  adv_len;
    logic        has_char;
    logic [7:0]  char_val;
    logic [6:0]  char_pos;
    logic        fin;
    logic [1:0]  fin_reason;
    logic [13:0] next_start;
    logic [7:0]  seen_inc;
    logic [7:0]  body_inc;
    t_result     char_res;
    t_result     sum_res;

    // per-byte parse step
    always_comb begin
        c_phase  = r_phase;
        c_start  = r_start;
        c_code   = r_code;
        c_link   = r_link;
        c_body   = r_body;
        c_seen   = r_seen;
        c_size   = r_size;
        c_vendor = r_vendor;
        c_card   = r_card;
        c_base   = r_base;
        c_chars  = r_chars;
        c_trim   = r_trim;
        if (i_start_of_image) begin
            c_phase  = PH_CODE;
            c_start  = '0;
            c_code   = '0;
            c_link   = '0;
            c_body   = '0;
            c_seen   = '0;
            c_size   = '0;
            c_vendor = '0;
            c_card   = '0;
            c_base   = BASE_DEFAULT;
            c_chars  = '0;
            c_trim   = '0;
        end

        n_phase  = c_phase;
        n_start  = c_start;
        n_code   = c_code;
        n_link   = c_link;
        n_body   = c_body;
        n_seen   = c_seen;
        n_size   = c_size;
        n_vendor = c_vendor;
        n_card   = c_card;
        n_base   = c_base;
        n_chars  = c_chars;
        n_trim   = c_trim;

        end_code = 1'b0;
        complete = 1'b0;
        do_adv   = 1'b0;
        adv_len  = 9'd1;
        has_char = 1'b0;
        char_val = '0;
        char_pos = '0;
        body_inc = c_body + 8'd1;

        case (c_phase)
            PH_CODE: begin
                n_code = i_attr_byte;
                if (i_attr_byte == CODE_END) begin
                    end_code = 1'b1;
                end else if (i_attr_byte == CODE_NULL) begin
                    do_adv  = 1'b1;
                    adv_len = 9'd1;
                end else begin
                    if (i_attr_byte == CODE_MANF) begin
                        n_vendor = '0;
                        n_card   = '0;
                    end
                    if (i_attr_byte == CODE_CONFIG) begin
                        n_size = '0;
                        n_base = '0;
                    end
                    n_phase = PH_LINK;
                end
            end
            PH_LINK: begin
                n_link = i_attr_byte;
                n_body = '0;
                if (i_attr_byte == 8'd0) begin
                    complete = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                // body field capture by tuple code
                if (c_code == CODE_MANF) begin
                    case (c_body)
                        8'd0:    n_vendor = {c_vendor[15:8], i_attr_byte};
                        8'd1:    n_vendor = {i_attr_byte, c_vendor[7:0]};
                        8'd2:    n_card   = {c_card[15:8], i_attr_byte};
                        8'd3:    n_card   = {i_attr_byte, c_card[7:0]};
                        default: n_vendor = c_vendor;
                    endcase
                end else if (c_code == CODE_CONFIG) begin
                    if (c_body == 8'd0) begin
                        n_size = i_attr_byte[1:0] & SIZE_MASK;
                    end else if (c_body == 8'd2) begin
                        n_base = {8'd0, i_attr_byte};
                    end else if (c_body == 8'd3 && c_size != 2'd0) begin
                        n_base = {i_attr_byte, c_base[7:0]};
                    end
                end else if (c_code == CODE_VERSION && c_body >= 8'd2 &&
                             c_chars < CHAR_CAP) begin
                    has_char = 1'b1;
                    char_val = (i_attr_byte == CHAR_NUL) ? CHAR_SPACE : i_attr_byte;
                    char_pos = c_chars;
                    n_chars  = c_chars + 7'd1;
                    if (char_val != CHAR_SPACE) begin
                        n_trim = c_chars + 7'd1;
                    end
                end
                n_body = body_inc;
                if (body_inc >= c_link) begin
                    complete = 1'b1;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase

        // tuple completion and walk end checks
        if (complete && n_link != LINK_END) begin
            do_adv  = 1'b1;
            adv_len = {1'b0, n_link} + 9'd2;
        end
        fin        = 1'b0;
        fin_reason = END_CODE;
        next_start = {1'b0, c_start} + {5'd0, adv_len};
        seen_inc   = c_seen + 8'd1;
        if (end_code) begin
            fin        = 1'b1;
            fin_reason = END_CODE;
        end else if (complete && n_link == LINK_END) begin
            fin        = 1'b1;
            fin_reason = END_LINK;
        end else if (do_adv) begin
            n_seen = seen_inc;
            if (next_start >= BOUND) begin
                fin        = 1'b1;
                fin_reason = END_BOUND;
            end else if (seen_inc >= TUPLE_CAP) begin
                fin        = 1'b1;
                fin_reason = END_TUPLES;
            end else begin
                n_start = next_start[12:0];
                n_phase = PH_CODE;
            end
        end
        if (fin) begin
            n_phase = PH_DONE;
        end

        // result records
        char_res               = '0;
        char_res.result_kind   = KIND_CHAR;
        char_res.char_value    = char_val;
        char_res.char_position = char_pos;

        sum_res                 = '0;
        sum_res.result_kind     = KIND_SUMMARY;
        sum_res.manufacturer_id = n_vendor;
        sum_res.card_id         = n_card;
        sum_res.config_base     = n_base;
        sum_res.version_length  = n_trim;
        sum_res.end_reason      = fin_reason;
        sum_res.last            = 1'b1;

        o_push.count  = i_take ? (2'({1'b0, has_char}) + 2'({1'b0, fin})) : 2'd0;
        o_push.first  = has_char ? char_res : sum_res;
        o_push.second = sum_res;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_start  <= '0;
            r_code   <= '0;
            r_link   <= '0;
            r_body   <= '0;
            r_seen   <= '0;
            r_size   <= '0;
            r_vendor <= '0;
            r_card   <= '0;
            r_base   <= BASE_DEFAULT;
            r_chars  <= '0;
            r_trim   <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_start  <= n_start;
            r_code   <= n_code;
            r_link   <= n_link;
            r_body   <= n_body;
            r_seen   <= n_seen;
            r_size   <= n_size;
            r_vendor <= n_vendor;
            r_card   <= n_card;
            r_base   <= n_base;
            r_chars  <= n_chars;
            r_trim   <= n_trim;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cit_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cit_out_queue
// Four-entry result queue: takes up to two results a cycle from the walker,
// presents the oldest one on the output channel.
// ----------------------------------------------------------------------------
module cit_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cit_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output cit_pkg::t_result    o_head
);
    import cit_pkg::*;

    localparam int DEPTH = 4;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    t_result    sh  [DEPTH];
    logic [2:0] r_count, n_count;
    logic [2:0] kept;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_q[0];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && i_ready;

    // shift on output transfer, then append new results
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            sh[i] = pop ? r_q[i + 1] : r_q[i];
        end
        sh[DEPTH - 1] = r_q[DEPTH - 1];
        kept = r_count - {2'd0, pop};
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = sh[i];
            if (i_push.count != 2'd0 && 3'(i) == kept) begin
                n_q[i] = i_push.first;
            end
            if (i_push.count == 2'd2 && 3'(i) == kept + 3'd1) begin
                n_q[i] = i_push.second;
            end
        end
        n_count = kept + {1'b0, i_push.count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule
`default_nettype wire

### rtl/core/card_info_tuple_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// card_info_tuple_parser
// Walks a card information structure one attribute byte at a time and
// reports version characters and a closing summary.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : attribute bytes, one per transfer; start_of_image on the first
//           byte restarts the walk. Bytes before a start or after the walk
//           has ended are consumed without results.
//   o_out : results. A version tuple yields one character result per body
//           byte from the third on (up to 79); the walk closes with one
//           summary result (last = 1) carrying IDs, config base, trimmed
//           version length and end reason.
//   Throughput: one byte per cycle while i_in.ready is high. A byte yields zero, one or two results.
//   Results are registered in the result queue and reach o_out behind any older results.
//   A four-entry result queue decouples the two sides; i_in.ready drops
//   only while more than two results are waiting, so a stalled receiver
//   stops input before the queue overflows and nothing is lost.
//   Reset (synchronous, active low) empties the queue and leaves the walk
//   idle until a byte with start_of_image arrives.
// ----------------------------------------------------------------------------
module card_info_tuple_parser (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cit_in_if.sink    i_in,
    cit_out_if.source o_out
);
    import cit_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    take;

    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    // tuple walk
    cit_walker u_walker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_start_of_image (i_in.start_of_image),
        .i_attr_byte      (i_in.attr_byte),
        .o_push           (push)
    );

    // result queue
    cit_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    // output payload
    assign o_out.result_kind     = head.result_kind;
    assign o_out.char_value      = head.char_value;
    assign o_out.char_position   = head.char_position;
    assign o_out.manufacturer_id = head.manufacturer_id;
    assign o_out.card_id         = head.card_id;
    assign o_out.config_base     = head.config_base;
    assign o_out.version_length  = head.version_length;
    assign o_out.end_reason      = head.end_reason;
    assign o_out.last            = head.last;

endmodule
`default_nettype wire
